[sv/sacr_pkg.sv]
// Shared constants, types and helper functions of the cache replacement block.
`default_nettype none
package sacr_pkg;

    localparam int ADDR_W         = 64;
    localparam int STAMP_W        = 32;
    localparam int POLICY_W       = 2;
    localparam int WAY_OUT_W      = 3;

    localparam int CACHE_BYTES_DEF = 64;
    localparam int BLOCK_BYTES_DEF = 8;
    localparam int WAYS_DEF        = 2;

    typedef enum logic [POLICY_W-1:0] {
        POL_LRU  = 2'd0,
        POL_FIFO = 2'd1,
        POL_LFU  = 2'd2
    } t_policy;

    function automatic int floor_log2(input int v);
        int n;
        n = 0;
        for (int b = 1; b < 32; b++) begin
            if ((v >> b) != 0) begin
                n = b;
            end
        end
        return n;
    endfunction

    function automatic logic [STAMP_W-1:0] sat_inc(input logic [STAMP_W-1:0] v);
        return (v == '1) ? v : v + STAMP_W'(1);
    endfunction

endpackage
`default_nettype wire

[sv/sacr_if.sv]
// Handshake interfaces for the address request and the lookup result channels.
`default_nettype none
interface sacr_req_if;
    logic                        valid;
    logic                        ready;
    logic [sacr_pkg::ADDR_W-1:0] addr;

    modport source (output valid, output addr, input ready);
    modport sink   (input valid, input addr, output ready);
endinterface

interface sacr_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic [sacr_pkg::WAY_OUT_W-1:0] way_used;
    logic                           evicted_valid;
    logic [sacr_pkg::STAMP_W-1:0]   hit_count;
    logic [sacr_pkg::STAMP_W-1:0]   miss_count;

    modport source (output valid, output hit, output way_used, output evicted_valid,
                    output hit_count, output miss_count, input ready);
    modport sink   (input valid, input hit, input way_used, input evicted_valid,
                    input hit_count, input miss_count, output ready);
endinterface
`default_nettype wire

[sv/set_assoc_cache_replacement.sv]
// Set-associative tag store: looks up one address word per cycle when not
// stalled and, on a miss, fills a free way or else picks a victim by LRU,
// FIFO or LFU. One row of the set RAM holds all ways of a set. An accepted
// address reads its set row at the accept edge; the stage that holds the
// address then compares tags, picks the way and, when it advances, writes
// the row back and loads the result into the output register. A new word
// is taken every cycle while the output is drained. A back-to-back access
// to the same set takes the row forwarded from the write-back. After reset
// a clearing pass writes each of the 2**floor(log2(sets)) set rows (4 with
// the defaults), and no word is taken during it; policy writes are taken
// at any time.
`default_nettype none
module set_assoc_cache_replacement #(
    parameter int CACHE_BYTES = sacr_pkg::CACHE_BYTES_DEF,
    parameter int BLOCK_BYTES = sacr_pkg::BLOCK_BYTES_DEF,
    parameter int WAYS        = sacr_pkg::WAYS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [sacr_pkg::POLICY_W-1:0] i_cfg_wdata,
    sacr_req_if.sink                           i_req,
    sacr_rsp_if.source                         o_rsp
);
    import sacr_pkg::*;

    localparam int OB        = floor_log2(BLOCK_BYTES);
    localparam int SETS_RAW  = CACHE_BYTES / (BLOCK_BYTES * WAYS);
    localparam int NSETS     = (SETS_RAW < 1) ? 1 : SETS_RAW;
    localparam int IB        = floor_log2(NSETS);
    localparam int SET_DEPTH = 1 << IB;
    localparam int SET_AW    = (IB > 0) ? IB : 1;
    localparam int TAG_SH    = OB + IB;
    localparam int TAG_W     = ADDR_W - TAG_SH;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W     = WAYS * (1 + TAG_W + 3 * STAMP_W);
    localparam logic [SET_AW-1:0] SET_MASK = SET_AW'(SET_DEPTH - 1);
    localparam logic [SET_AW-1:0] SET_LAST = SET_AW'(SET_DEPTH - 1);

    t_policy                  r_policy;
    logic                     r_clr_busy;
    logic [SET_AW-1:0]        r_clr_idx;
    logic                     r_s1_valid;
    logic [ADDR_W-1:0]        r_s1_addr;
    logic                     r_fwd_hit;
    logic [ROW_W-1:0]         r_fwd_row;
    logic [STAMP_W-1:0]       r_clock;
    logic [STAMP_W-1:0]       r_hit_total;
    logic [STAMP_W-1:0]       r_miss_total;
    logic                     r_out_valid;
    logic                     r_out_hit;
    logic [WAY_OUT_W-1:0]     r_out_way;
    logic                     r_out_evict;
    logic [STAMP_W-1:0]       r_out_hcnt;
    logic [STAMP_W-1:0]       r_out_mcnt;

    logic                     en;
    logic                     s1_adv;
    logic                     in_ready;
    logic                     in_acc;
    logic [ADDR_W-1:0]        in_sh;
    logic [SET_AW-1:0]        in_set;
    logic [ADDR_W-1:0]        s1_sh;
    logic [ADDR_W-1:0]        s1_tsh;
    logic [SET_AW-1:0]        s1_set;
    logic [TAG_W-1:0]         s1_tag;

    logic [ROW_W-1:0]         ram_rdata;
    logic                     ram_we;
    logic [SET_AW-1:0]        ram_waddr;
    logic [ROW_W-1:0]         ram_wdata;
    logic [ROW_W-1:0]         cur_row;

    logic [WAYS-1:0]                  cur_valid;
    logic [WAYS-1:0][TAG_W-1:0]       cur_tag;
    logic [WAYS-1:0][STAMP_W-1:0]     cur_last;
    logic [WAYS-1:0][STAMP_W-1:0]     cur_fill;
    logic [WAYS-1:0][STAMP_W-1:0]     cur_cnt;
    logic [WAYS-1:0]                  n_valid;
    logic [WAYS-1:0][TAG_W-1:0]       n_tag;
    logic [WAYS-1:0][STAMP_W-1:0]     n_last;
    logic [WAYS-1:0][STAMP_W-1:0]     n_fill;
    logic [WAYS-1:0][STAMP_W-1:0]     n_cnt;
    logic [ROW_W-1:0]                 n_row;

    logic                     s1_hit;
    logic                     any_inv;
    logic [WAY_W-1:0]         hit_way;
    logic [WAY_W-1:0]         inv_way;
    logic [WAY_W-1:0]         vic_way;
    logic [WAY_W-1:0]         way_sel;
    logic                     s1_evict;
    logic [STAMP_W-1:0]       n_clock;
    logic [STAMP_W-1:0]       n_hit_total;
    logic [STAMP_W-1:0]       n_miss_total;

    // Handshake and address split
    assign en       = !r_out_valid || o_rsp.ready;
    assign s1_adv   = r_s1_valid && en;
    assign in_ready = !r_clr_busy && (!r_s1_valid || en);
    assign in_acc   = i_req.valid && in_ready;
    assign i_req.ready = in_ready;

    assign in_sh  = i_req.addr >> OB;
    assign in_set = in_sh[SET_AW-1:0] & SET_MASK;
    assign s1_sh  = r_s1_addr >> OB;
    assign s1_set = s1_sh[SET_AW-1:0] & SET_MASK;
    assign s1_tsh = r_s1_addr >> TAG_SH;
    assign s1_tag = s1_tsh[TAG_W-1:0];

    sacr_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SET_DEPTH)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (in_set),
        .o_rdata (ram_rdata)
    );

    assign ram_we    = r_clr_busy || s1_adv;
    assign ram_waddr = r_clr_busy ? r_clr_idx : s1_set;
    assign ram_wdata = r_clr_busy ? '0 : n_row;

    assign cur_row = r_fwd_hit ? r_fwd_row : ram_rdata;
    assign {cur_valid, cur_tag, cur_last, cur_fill, cur_cnt} = cur_row;
    assign n_row = {n_valid, n_tag, n_last, n_fill, n_cnt};

    // Tag compare and victim choice
    always_comb begin
        logic take;
        s1_hit  = 1'b0;
        hit_way = '0;
        any_inv = 1'b0;
        inv_way = '0;
        vic_way = '0;
        take    = 1'b0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (cur_valid[w] && (cur_tag[w] == s1_tag)) begin
                s1_hit  = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!cur_valid[w]) begin
                any_inv = 1'b1;
                inv_way = WAY_W'(w);
            end
        end
        for (int w = 1; w < WAYS; w++) begin
            case (r_policy)
                POL_LRU:  take = cur_last[w] < cur_last[vic_way];
                POL_FIFO: take = cur_fill[w] < cur_fill[vic_way];
                POL_LFU:  take = (cur_cnt[w] < cur_cnt[vic_way]) ||
                                 ((cur_cnt[w] == cur_cnt[vic_way]) &&
                                  (cur_fill[w] < cur_fill[vic_way]));
                default:  take = 1'b0;
            endcase
            if (take) begin
                vic_way = WAY_W'(w);
            end
        end
        if (s1_hit) begin
            way_sel = hit_way;
        end else if (any_inv) begin
            way_sel = inv_way;
        end else begin
            way_sel = vic_way;
        end
        s1_evict = !s1_hit && !any_inv;
    end

    // Row and counter update
    always_comb begin
        n_clock      = sat_inc(r_clock);
        n_hit_total  = s1_hit ? sat_inc(r_hit_total) : r_hit_total;
        n_miss_total = s1_hit ? r_miss_total : sat_inc(r_miss_total);
        n_valid = cur_valid;
        n_tag   = cur_tag;
        n_last  = cur_last;
        n_fill  = cur_fill;
        n_cnt   = cur_cnt;
        if (s1_hit) begin
            n_last[way_sel] = n_clock;
            n_cnt[way_sel]  = sat_inc(cur_cnt[way_sel]);
        end else begin
            n_valid[way_sel] = 1'b1;
            n_tag[way_sel]   = s1_tag;
            n_last[way_sel]  = n_clock;
            n_fill[way_sel]  = n_clock;
            n_cnt[way_sel]   = STAMP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy     <= POL_LRU;
            r_clr_busy   <= 1'b1;
            r_clr_idx    <= '0;
            r_s1_valid   <= 1'b0;
            r_fwd_hit    <= 1'b0;
            r_clock      <= '0;
            r_hit_total  <= '0;
            r_miss_total <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_policy <= t_policy'(i_cfg_wdata);
            end
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + SET_AW'(1);
                if (r_clr_idx == SET_LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= s1_adv && (s1_set == in_set);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_clock      <= n_clock;
                r_hit_total  <= n_hit_total;
                r_miss_total <= n_miss_total;
            end
            if (en) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_addr <= i_req.addr;
            r_fwd_row <= n_row;
        end
        if (s1_adv) begin
            r_out_hit   <= s1_hit;
            r_out_way   <= WAY_OUT_W'(way_sel);
            r_out_evict <= s1_evict;
            r_out_hcnt  <= n_hit_total;
            r_out_mcnt  <= n_miss_total;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.hit           = r_out_hit;
    assign o_rsp.way_used      = r_out_way;
    assign o_rsp.evicted_valid = r_out_evict;
    assign o_rsp.hit_count     = r_out_hcnt;
    assign o_rsp.miss_count    = r_out_mcnt;

    a_no_hit_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_hit && r_out_evict))
        else $error("hit reported together with eviction");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !in_ready)
        else $error("word taken during clearing pass");

    a_miss_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && !s1_hit && (r_miss_total != '1)) |=>
            (r_miss_total == $past(r_miss_total) + STAMP_W'(1)))
        else $error("miss total did not advance");

    a_way_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ({1'b0, r_out_way} < (WAY_OUT_W + 1)'(WAYS)))
        else $error("way out of range");

endmodule
`default_nettype wire

[sv/sacr_ram.sv]
// Generic single-write, single-read RAM with registered read-first output.
`default_nettype none
module sacr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

endmodule
`default_nettype wire
